// ===== src/sgm_pkg.sv =====
// Shared types and constants for the Scharr gradient magnitude block.
`default_nettype none

package sgm_pkg;

   // Frame geometry
   localparam int MAX_WIDTH  = 4096;
   localparam int PIX_W      = 8;
   localparam int COL_W      = 12;
   localparam int ROW_W      = 16;
   localparam int WIDTH_W    = 13;
   localparam int HEIGHT_W   = 16;
   localparam int GAIN_W     = 18;
   localparam int MIN_DIM    = 3;

   // Configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 18;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_NORM_GAIN    = 2'd2;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 18'd65536;

   // Datapath widths
   localparam int LINE_W    = 2 * PIX_W;          // {two rows above, row above}
   localparam int GRAD_W    = 13;                 // |g| <= 4080, signed
   localparam int SQ_W      = 25;                 // gx^2 + gy^2 < 2^25
   localparam int SQR_W     = SQ_W - 1;           // one square < 2^24
   localparam int ROOT_W    = 13;                 // floor sqrt < 2^13
   localparam int SQRT_IN_W = 2 * ROOT_W;
   localparam int REM_W     = ROOT_W + 2;
   localparam int PROD_W    = ROOT_W + GAIN_W;
   localparam int GAIN_FRAC = 16;
   localparam int SCALED_W  = PROD_W - GAIN_FRAC;

   // Result queue
   localparam int FIFO_DEPTH = 32;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int CREDIT_W   = FIFO_AW + 1;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } sgm_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] magnitude;
      logic [COL_W-1:0] out_col;
      logic [ROW_W-1:0] out_row;
      logic             frame_last;
   } sgm_rsp_type;

   // Coordinates that ride along with a pixel through the datapath
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             last;
   } sgm_side_type;

endpackage

`default_nettype wire

// ===== src/sgm_isqrt.sv =====
// Pipelined integer floor square root, one result bit per stage.
`default_nettype none

module sgm_isqrt
   import sgm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [SQ_W-1:0]   in_value,
   input  wire sgm_side_type      in_side,
   output logic                   out_valid,
   output logic [ROOT_W-1:0]      out_root,
   output sgm_side_type           out_side
);

   logic [ROOT_W-1:0]    valid_ff;
   logic [REM_W-1:0]     rem_ff  [0:ROOT_W-1];
   logic [ROOT_W-1:0]    root_ff [0:ROOT_W-1];
   logic [SQRT_IN_W-1:0] val_ff  [0:ROOT_W-1];
   sgm_side_type         side_ff [0:ROOT_W-1];

   logic [REM_W-1:0]     rem_cur  [0:ROOT_W-1];
   logic [ROOT_W-1:0]    root_cur [0:ROOT_W-1];
   logic [SQRT_IN_W-1:0] val_cur  [0:ROOT_W-1];
   logic [REM_W-1:0]     rem_in   [0:ROOT_W-1];
   logic [ROOT_W-1:0]    root_in  [0:ROOT_W-1];
   logic [SQRT_IN_W-1:0] val_in   [0:ROOT_W-1];

   // Stage k takes the next two radicand bits and decides one root bit.
   always_comb begin
      logic [REM_W+1:0] ext;
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] diff;
      logic             ge;
      rem_cur[0]  = '0;
      root_cur[0] = '0;
      val_cur[0]  = SQRT_IN_W'(in_value);
      for (int k = 1; k < ROOT_W; k++) begin
         rem_cur[k]  = rem_ff[k-1];
         root_cur[k] = root_ff[k-1];
         val_cur[k]  = val_ff[k-1];
      end
      for (int k = 0; k < ROOT_W; k++) begin
         ext   = {rem_cur[k], val_cur[k][SQRT_IN_W-1 -: 2]};
         trial = (REM_W + 2)'({root_cur[k], 2'b01});
         diff  = ext - trial;
         ge    = (ext >= trial);
         rem_in[k]  = ge ? diff[REM_W-1:0] : ext[REM_W-1:0];
         root_in[k] = {root_cur[k][ROOT_W-2:0], ge};
         val_in[k]  = val_cur[k] << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[ROOT_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= in_side;
      for (int k = 0; k < ROOT_W; k++) begin
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         val_ff[k]  <= val_in[k];
      end
      for (int k = 1; k < ROOT_W; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

`default_nettype wire

// ===== src/scharr_gradient_magnitude.sv =====
// Top level of the streaming 3x3 Scharr gradient magnitude block.
`default_nettype none

// Gray pixels arrive in raster order, one transfer per pixel, and for every
// interior pixel the block returns min(255, (isqrt(gx^2 + gy^2) * norm_gain)
// >> 16) with its column, row and an end-of-frame flag; border pixels and
// frames narrower or shorter than three give no result. The block takes one
// pixel per clock sustained while req_stall is low. A pixel passes through the
// line store access, window, gradient and squaring stages, thirteen square root
// stages and a gain stage before its result enters the queue. The line store
// is a single 4096 x 16 memory holding the two previous rows, read and written
// back once per pixel with a bypass for back-to-back hits on one column. Up to
// 32 pixels, in flight or queued, may be outstanding; results collect in a 32-entry
// queue, so req_stall rises only once rsp_stall has held back enough results.
// There is no clearing pass after reset: line store entries become meaningful
// once written by the row above. Write configuration only while idle.

module scharr_gradient_magnitude
   import sgm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire sgm_req_type           req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output sgm_rsp_type                rsp_payload,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // ---------------------------------------------------------------- config
   logic [WIDTH_W-1:0]  image_width_ff;
   logic [HEIGHT_W-1:0] image_height_ff;
   logic [GAIN_W-1:0]   norm_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
         norm_gain_ff    <= GAIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[HEIGHT_W-1:0];
            CSR_NORM_GAIN:    norm_gain_ff    <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Widths above the line store depth saturate at the depth.
   logic [WIDTH_W-1:0] width_eff;
   assign width_eff = (image_width_ff > WIDTH_W'(MAX_WIDTH)) ?
                      WIDTH_W'(MAX_WIDTH) : image_width_ff;

   // ------------------------------------------------------ flow control
   logic                req_accept;
   logic                rsp_pop;
   logic                credit_rel;
   logic [CREDIT_W-1:0] credit_ff;
   logic [CREDIT_W-1:0] credit_in;

   // One credit per outstanding pixel: it returns when the pixel drops out
   // as a border pixel or when its result leaves the queue.
   assign req_stall  = (credit_ff == CREDIT_W'(FIFO_DEPTH));
   assign req_accept = req_valid && !req_stall;
   assign credit_in  = credit_ff + CREDIT_W'(req_accept)
                       - CREDIT_W'(credit_rel) - CREDIT_W'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   // ------------------------------------------------------ position counters
   logic [COL_W-1:0]   col_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [COL_W-1:0]   col_in;
   logic [ROW_W-1:0]   row_in;
   logic [COL_W-1:0]   col_sel;
   logic [ROW_W-1:0]   row_sel;
   logic [COL_W:0]     col_inc;
   logic [ROW_W:0]     row_inc;
   logic               row_end;
   logic               frame_end;
   logic               pix_emit;
   sgm_side_type       pix_side;

   assign col_sel   = req_payload.frame_start ? '0 : col_ff;
   assign row_sel   = req_payload.frame_start ? '0 : row_ff;
   assign col_inc   = {1'b0, col_sel} + (COL_W + 1)'(1);
   assign row_inc   = {1'b0, row_sel} + (ROW_W + 1)'(1);
   assign row_end   = (col_inc >= width_eff);
   assign frame_end = (row_inc >= {1'b0, image_height_ff});

   // Interior pixel (c-1, r-1) completes when pixel (c, r) arrives.
   assign pix_emit = (width_eff >= WIDTH_W'(MIN_DIM))
                     && (image_height_ff >= HEIGHT_W'(MIN_DIM))
                     && (col_sel >= COL_W'(2)) && (row_sel >= ROW_W'(2));
   assign pix_side.col  = col_sel - COL_W'(1);
   assign pix_side.row  = row_sel - ROW_W'(1);
   assign pix_side.last = (col_inc == width_eff)
                          && (row_inc == {1'b0, image_height_ff});

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_inc[ROW_W-1:0];
         end else begin
            col_in = col_inc[COL_W-1:0];
            row_in = row_sel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------ stage 1: line store access
   logic               p1_valid_ff;
   logic               p1_emit_ff;
   logic [PIX_W-1:0]   p1_pix_ff;
   logic [COL_W-1:0]   p1_col_ff;
   sgm_side_type       p1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      p1_emit_ff <= pix_emit;
      p1_pix_ff  <= req_payload.pixel;
      p1_col_ff  <= col_sel;
      p1_side_ff <= pix_side;
   end

   // Line store: upper byte two rows above, lower byte one row above.
   logic [LINE_W-1:0] line_mem [0:MAX_WIDTH-1];
   logic [LINE_W-1:0] line_rd_ff;
   logic [LINE_W-1:0] byp_data_ff;
   logic              byp_ff;
   logic [LINE_W-1:0] line_fetch;
   logic [LINE_W-1:0] line_wdata;

   // The write of stage 1 and the read for the next pixel share an edge;
   // forward the write data when both hit the same column.
   assign line_fetch = byp_ff ? byp_data_ff : line_rd_ff;
   assign line_wdata = {line_fetch[PIX_W-1:0], p1_pix_ff};

   always_ff @(posedge clock) begin
      if (p1_valid_ff) begin
         line_mem[p1_col_ff] <= line_wdata;
      end
      line_rd_ff  <= line_mem[col_sel];
      byp_ff      <= p1_valid_ff && (p1_col_ff == col_sel);
      byp_data_ff <= line_wdata;
   end

   // Drop border pixels here and hand their credit back.
   assign credit_rel = p1_valid_ff && !p1_emit_ff;

   // ------------------------------------------------ stage 2: 3x3 window
   logic [PIX_W-1:0] win_ff [0:2][0:2];   // [row, top first][column, left first]
   logic             p2_valid_ff;
   sgm_side_type     p2_side_ff;

   always_ff @(posedge clock) begin
      if (p1_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= win_ff[k][2];
         end
         win_ff[0][2] <= line_fetch[LINE_W-1:PIX_W];
         win_ff[1][2] <= line_fetch[PIX_W-1:0];
         win_ff[2][2] <= p1_pix_ff;
      end
      p2_side_ff <= p1_side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff && p1_emit_ff;
      end
   end

   // ------------------------------------------------ stage 3: gradients
   logic signed [GRAD_W-1:0] tl, tc, tr, ml, mr, bl, bc, br;
   logic signed [GRAD_W-1:0] gx_in, gy_in;
   logic signed [GRAD_W-1:0] gx_ff, gy_ff;
   logic                     p3_valid_ff;
   sgm_side_type             p3_side_ff;

   assign tl = $signed(GRAD_W'(win_ff[0][0]));
   assign tc = $signed(GRAD_W'(win_ff[0][1]));
   assign tr = $signed(GRAD_W'(win_ff[0][2]));
   assign ml = $signed(GRAD_W'(win_ff[1][0]));
   assign mr = $signed(GRAD_W'(win_ff[1][2]));
   assign bl = $signed(GRAD_W'(win_ff[2][0]));
   assign bc = $signed(GRAD_W'(win_ff[2][1]));
   assign br = $signed(GRAD_W'(win_ff[2][2]));

   assign gx_in = GRAD_W'(3) * (tl - tr) + GRAD_W'(10) * (ml - mr)
                  + GRAD_W'(3) * (bl - br);
   assign gy_in = GRAD_W'(3) * (tl - bl) + GRAD_W'(10) * (tc - bc)
                  + GRAD_W'(3) * (tr - br);

   always_ff @(posedge clock) begin
      gx_ff      <= gx_in;
      gy_ff      <= gy_in;
      p3_side_ff <= p2_side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   // ------------------------------------------------ stage 4: squares
   logic signed [2*GRAD_W-1:0] gx_sq;
   logic signed [2*GRAD_W-1:0] gy_sq;
   logic [SQR_W-1:0]           sqx_ff, sqy_ff;
   logic                       p4_valid_ff;
   sgm_side_type               p4_side_ff;
   logic [SQ_W-1:0]            sq_sum;

   assign gx_sq = gx_ff * gx_ff;
   assign gy_sq = gy_ff * gy_ff;

   always_ff @(posedge clock) begin
      sqx_ff     <= gx_sq[SQR_W-1:0];
      sqy_ff     <= gy_sq[SQR_W-1:0];
      p4_side_ff <= p3_side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else begin
         p4_valid_ff <= p3_valid_ff;
      end
   end

   assign sq_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   // ------------------------------------------------ square root
   logic              root_valid;
   logic [ROOT_W-1:0] root;
   sgm_side_type      root_side;

   sgm_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p4_valid_ff),
      .in_value  (sq_sum),
      .in_side   (p4_side_ff),
      .out_valid (root_valid),
      .out_root  (root),
      .out_side  (root_side)
   );

   // ------------------------------------------------ gain and clamp
   logic [PROD_W-1:0]   prod_ff;
   logic                p5_valid_ff;
   sgm_side_type        p5_side_ff;
   logic [SCALED_W-1:0] scaled;
   sgm_rsp_type         push_data;

   always_ff @(posedge clock) begin
      prod_ff    <= PROD_W'(root) * PROD_W'(norm_gain_ff);
      p5_side_ff <= root_side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_valid_ff <= 1'b0;
      end else begin
         p5_valid_ff <= root_valid;
      end
   end

   assign scaled = prod_ff[PROD_W-1:GAIN_FRAC];
   assign push_data.magnitude  = (|scaled[SCALED_W-1:PIX_W]) ? '1 : scaled[PIX_W-1:0];
   assign push_data.out_col    = p5_side_ff.col;
   assign push_data.out_row    = p5_side_ff.row;
   assign push_data.frame_last = p5_side_ff.last;

   // ------------------------------------------------ result queue
   sgm_rsp_type        fifo_ff [0:FIFO_DEPTH-1];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   fill_ff, fill_in;
   logic               fifo_push;

   assign fifo_push   = p5_valid_ff;
   assign rsp_valid   = (fill_ff != '0);
   assign rsp_pop     = rsp_valid && !rsp_stall;
   assign rsp_payload = fifo_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + FIFO_AW'(fifo_push);
   assign rd_ptr_in = rd_ptr_ff + FIFO_AW'(rsp_pop);
   assign fill_in   = fill_ff + (FIFO_AW + 1)'(fifo_push) - (FIFO_AW + 1)'(rsp_pop);

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

`ifndef SYNTHESIS
   // Outstanding pixels never exceed the queue depth.
   assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CREDIT_W'(FIFO_DEPTH))
      else $error("credit count above queue depth");

   // Every queued result still holds its credit.
   assert property (@(posedge clock) disable iff (reset)
      {1'b0, fill_ff} <= (CREDIT_W + 1)'(credit_ff))
      else $error("queue holds more results than outstanding pixels");

   // Credits keep the queue from overflowing.
   assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> (fill_ff != (FIFO_AW + 1)'(FIFO_DEPTH)))
      else $error("push into full result queue");
`endif

endmodule

`default_nettype wire

// ===== tb/scharr_gradient_magnitude_checker.sv =====
`timescale 1ns / 100ps
// Checker: predicts Scharr gradient magnitudes from pixel transfers and compares results.
module scharr_gradient_magnitude_checker
   import sgm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire sgm_req_type           req_payload,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire sgm_rsp_type           rsp_payload,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [31:0]                mismatch_count,
   output logic [31:0]                awaiting_count
);

   localparam int REPORT_LIMIT = 10;

   logic [PIX_W-1:0]    above_row     [MAX_WIDTH];
   logic [PIX_W-1:0]    two_above_row [MAX_WIDTH];
   logic [PIX_W-1:0]    nbhd [3][3];   // [0 top .. 2 bottom][0 left .. 2 right]
   int unsigned         col_pos;
   int unsigned         row_pos;
   logic [WIDTH_W-1:0]  cfg_width;
   logic [HEIGHT_W-1:0] cfg_height;
   logic [GAIN_W-1:0]   cfg_gain;
   sgm_rsp_type         expected_edges [$];
   int                  errors;

   initial begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
         above_row[i]     = '0;
         two_above_row[i] = '0;
      end
      errors         = 0;
      mismatch_count = '0;
      awaiting_count = '0;
   end

   // Bitwise search for the floor square root
   function automatic int unsigned floor_root(input int unsigned v);
      int unsigned root;
      int unsigned trial;
      root = 0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   // Advance the window and line stores by one pixel; queue a result for interior pixels
   task automatic take_pixel(input sgm_req_type item);
      int unsigned     eff_w;
      int unsigned     c;
      int unsigned     r;
      int              tl, tc, tr, ml, mr, bl, bc, br;
      int              gx, gy;
      longint unsigned root;
      longint unsigned scaled;
      sgm_rsp_type     res;

      eff_w = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
      if (item.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = (col_pos >= MAX_WIDTH) ? 0 : col_pos;
      r = row_pos;

      for (int k = 0; k < 3; k++) begin
         nbhd[k][0] = nbhd[k][1];
         nbhd[k][1] = nbhd[k][2];
      end
      nbhd[0][2]       = two_above_row[c];
      nbhd[1][2]       = above_row[c];
      nbhd[2][2]       = item.pixel;
      two_above_row[c] = above_row[c];
      above_row[c]     = item.pixel;

      if (eff_w >= MIN_DIM && cfg_height >= MIN_DIM && c >= 2 && r >= 2) begin
         tl = nbhd[0][0]; tc = nbhd[0][1]; tr = nbhd[0][2];
         ml = nbhd[1][0];                  mr = nbhd[1][2];
         bl = nbhd[2][0]; bc = nbhd[2][1]; br = nbhd[2][2];
         gx = 3 * (tl - tr) + 10 * (ml - mr) + 3 * (bl - br);
         gy = 3 * (tl - bl) + 10 * (tc - bc) + 3 * (tr - br);
         root   = 64'(floor_root(gx * gx + gy * gy));
         scaled = (root * 64'(cfg_gain)) >> GAIN_FRAC;
         res.magnitude  = (scaled > 255) ? 8'hFF : scaled[PIX_W-1:0];
         res.out_col    = COL_W'(c - 1);
         res.out_row    = ROW_W'(r - 1);
         res.frame_last = (c + 1 == eff_w) && (r + 1 == cfg_height);
         expected_edges.push_back(res);
      end

      // wrap column, then row, at the frame edges
      if (c + 1 >= eff_w) begin
         col_pos = 0;
         row_pos = (r + 1 >= cfg_height) ? 0 : ((r + 1) & 32'hFFFF);
      end else begin
         col_pos = c + 1;
      end
   endtask

   always @(posedge clock) begin : watch
      sgm_rsp_type want;
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) nbhd[k][j] = '0;
         end
         col_pos    = 0;
         row_pos    = 0;
         cfg_width  = WIDTH_RESET;
         cfg_height = HEIGHT_RESET;
         cfg_gain   = GAIN_RESET;
         expected_edges.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  cfg_width  = csr_wdata[WIDTH_W-1:0];
               CSR_IMAGE_HEIGHT: cfg_height = csr_wdata[HEIGHT_W-1:0];
               CSR_NORM_GAIN:    cfg_gain   = csr_wdata[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) take_pixel(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (expected_edges.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("unexpected result: mag %0d col %0d row %0d last %0b",
                           rsp_payload.magnitude, rsp_payload.out_col,
                           rsp_payload.out_row, rsp_payload.frame_last);
            end else begin
               want = expected_edges.pop_front();
               if (want.magnitude  !== rsp_payload.magnitude ||
                   want.out_col    !== rsp_payload.out_col   ||
                   want.out_row    !== rsp_payload.out_row   ||
                   want.frame_last !== rsp_payload.frame_last) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("result differs: expected mag %0d col %0d row %0d last %0b, %s",
                              want.magnitude, want.out_col, want.out_row, want.frame_last,
                              $sformatf("got mag %0d col %0d row %0d last %0b",
                                        rsp_payload.magnitude, rsp_payload.out_col,
                                        rsp_payload.out_row, rsp_payload.frame_last));
               end
            end
         end
      end
      mismatch_count <= 32'(errors);
      awaiting_count <= 32'(expected_edges.size());
   end

endmodule

// ===== tb/scharr_gradient_magnitude_tb.sv =====
`timescale 1ns / 100ps
// Testbench top: pixel stimulus, result back pressure and verdict for the Scharr block.
module scharr_gradient_magnitude_tb;
   import sgm_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 40;     // longer than the pixel-to-result latency
   localparam int LONG_HOLD    = 400;    // long enough to fill the result queue
   localparam int RANDOM_ITEMS = 650;
   localparam int WIDE_ITEMS   = 96;     // partial first row of a wide frame
   localparam int GAIN_UNITY   = 65536;
   localparam int GAIN_TOP     = 262143;
   localparam int WIDTH_TOP    = 8191;   // widest value the register holds
   localparam int HEIGHT_TOP   = 65535;

   typedef enum int {PIX_UNIFORM, PIX_BINARY, PIX_SMOOTH, PIX_EXTREME} pixel_mode_type;
   typedef enum int {PAT_GENTLE, PAT_STEP, PAT_STEP_INV} pattern_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   sgm_req_type           req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   sgm_rsp_type           rsp_payload;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   logic [31:0] mismatch_total;
   logic [31:0] awaiting;

   int send_max     = 0;   // largest gap the pixel side draws before a transfer
   int recv_max     = 0;   // largest stall the result side draws before a transfer
   bit hold_request = 1'b0;
   bit hold_served  = 1'b0;
   int pixel_base   = 128;
   int cycle_count  = 0;

   scharr_gradient_magnitude dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   scharr_gradient_magnitude_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_total),
      .awaiting_count (awaiting)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: give up once the cycle budget is spent
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   // Result side: draw a stall before every transfer; once, when asked, hold off for a
   // long stretch so the result queue fills and the block pushes back on pixels.
   initial begin : result_side
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = $urandom_range(0, recv_max);
         if (hold_request && !hold_served) begin
            gap         = LONG_HOLD;
            hold_served = 1'b1;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Offer one pixel after a random gap and hold it until the transfer happens.
   // Valid stays high across back-to-back transfers; it drops only for a gap.
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
      int          gap;
      sgm_req_type item;
      gap              = $urandom_range(0, send_max);
      item.pixel       = pix;
      item.frame_start = fs;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // Write all three registers on consecutive edges; enable drops once, at the end
   task automatic configure(input int w, input int h, input int g);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= CSR_DATA_W'(w);
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= CSR_DATA_W'(h);
      @(posedge clock);
      csr_index <= CSR_NORM_GAIN;
      csr_wdata <= CSR_DATA_W'(g);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Wait for every predicted result, then let the pipeline drain pixels that give none.
   // The count read at an edge reflects transfers up to the edge before.
   task automatic wait_quiet();
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [PIX_W-1:0] next_pixel(input pixel_mode_type mode);
      int v;
      case (mode)
         PIX_BINARY: v = $urandom_range(0, 1) ? 255 : 0;
         PIX_SMOOTH: begin
            // drift slowly so gradients stay small and the gain decides the outcome
            v          = $urandom_range(0, 8);
            pixel_base = pixel_base + v - 4;
            if (pixel_base < 0)   pixel_base = 0;
            if (pixel_base > 255) pixel_base = 255;
            v = pixel_base;
         end
         PIX_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       v = 0;
               1:       v = 1;
               2:       v = 254;
               default: v = 255;
            endcase
         end
         default: v = $urandom_range(0, 255);
      endcase
      return v[PIX_W-1:0];
   endfunction

   function automatic int pick_gain();
      case ($urandom_range(0, 6))
         0:       return 0;
         1:       return GAIN_TOP;
         2:       return GAIN_UNITY;
         3:       return $urandom_range(1, 255);
         4:       return $urandom_range(256, 16383);
         default: return $urandom_range(0, GAIN_TOP);
      endcase
   endfunction

   function automatic int pick_idle();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 3;
         default: return 15;
      endcase
   endfunction

   // One minimal 3x3 frame with a fixed picture: exactly one interior result
   task automatic run_pattern(input pattern_type pat, input int g);
      logic [PIX_W-1:0] p;
      int               col;
      int               row;
      int               lvl;
      configure(MIN_DIM, MIN_DIM, g);
      for (int i = 0; i < 9; i++) begin
         col = i % 3;
         row = i / 3;
         // bright left edge, dark right edge, top-to-bottom ramp in the middle column
         lvl = (col == 0) ? 255 : (col == 2) ? 0 : (row == 0) ? 255 : (row == 1) ? 128 : 0;
         case (pat)
            PAT_GENTLE: p = (col == 2 && row == 1) ? 8'd103 : 8'd100;
            PAT_STEP:   p = PIX_W'(lvl);
            default:    p = PIX_W'(255 - lvl);
         endcase
         send_pixel(p, i == 0);
      end
      req_valid <= 1'b0;
      wait_quiet();
   endtask

   // Program a geometry, stream pixels (frame_start on the first, optionally at random
   // spots to break frames), then drain
   task automatic run_phase(input int w, input int h, input int g, input int count,
                            input bit noisy, input pixel_mode_type mode);
      configure(w, h, g);
      for (int i = 0; i < count; i++)
         send_pixel(next_pixel(mode), (i == 0) || (noisy && $urandom_range(0, 31) == 0));
      req_valid <= 1'b0;
      wait_quiet();
   endtask

   initial begin : pixel_side
      int             w, h, g, count, frames, idx, random_sent;
      bit             noisy;
      pixel_mode_type mode;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames: small signed gradient, clamped maximum, inverted step
      send_max = pick_idle();
      recv_max = pick_idle();
      run_pattern(PAT_GENTLE, GAIN_UNITY);
      run_pattern(PAT_STEP, GAIN_TOP);
      run_pattern(PAT_STEP_INV, 1000);

      // Random phases; the first few indexes pin down corner geometries
      random_sent = 0;
      idx         = 0;
      while (random_sent < RANDOM_ITEMS) begin
         send_max = pick_idle();
         recv_max = pick_idle();
         mode     = pixel_mode_type'($urandom_range(0, 3));
         g        = pick_gain();
         w        = $urandom_range(3, 12);
         h        = $urandom_range(3, 6);
         frames   = $urandom_range(1, 3);   // later frames follow without frame_start
         count    = frames * w * h;
         if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count);
         noisy    = ($urandom_range(0, 3) == 0);
         case (idx)
            0: begin w = 5; h = 5; g = 0; count = 25; end
            1: begin w = 0; h = 4; count = 12; end
            2: begin w = 3; h = HEIGHT_TOP; count = 120; end
            3: begin w = 1; h = 6; count = 10; end
            4: begin
               // fill the block while the result side holds off
               w = 12; h = 12; count = 144; noisy = 1'b0;
               send_max = 0; recv_max = 3;
               hold_request = 1'b1;
            end
            5: begin w = 2; h = 7; count = 14; end
            6: begin
               // widest frame: a partial first row advances the counters, no result
               w = MAX_WIDTH; h = 3; count = WIDE_ITEMS; noisy = 1'b0;
               send_max = 3; recv_max = 3;
            end
            7: begin w = 6; h = 0; count = 18; end
            8: begin w = 5; h = 1; count = 15; end
            9: begin w = 7; h = 2; count = 21; end
            10: begin
               // width beyond the line store: a partial first row, no result
               w = WIDTH_TOP; h = 3; count = WIDE_ITEMS; noisy = 1'b0;
               send_max = 3; recv_max = 3;
            end
            default: ;
         endcase
         run_phase(w, h, g, count, noisy, mode);
         random_sent += count;
         idx++;
      end

      if (mismatch_total == 0 && awaiting == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== scharr_gradient_magnitude.f =====
src/sgm_pkg.sv
src/sgm_isqrt.sv
src/scharr_gradient_magnitude.sv
tb/scharr_gradient_magnitude_checker.sv
tb/scharr_gradient_magnitude_tb.sv
